// ----- hdl/pwct_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwct_pkg
// Shared types and constants for the pulse-width code transmitter: field
// widths, register indexes, line phase codes and default timing parameters.
// ----------------------------------------------------------------------------
package pwct_pkg;

  // payload and register widths
  localparam int unsigned CodeWordW = 24;
  localparam int unsigned RepeatW   = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned TimeW     = 16;
  localparam int unsigned CountW    = 18;
  // wide enough for every signed interval sum before saturation
  localparam int unsigned CalcW     = 20;

  // default parameter values
  localparam int unsigned DefCodeBits      = 24;
  localparam int unsigned DefPulseExt      = 24;
  localparam int unsigned DefLatencyTicks  = 12;

  // item kinds
  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_START = 1'b1
  } kind_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_START_HIGH = 3'd0,
    REG_START_LOW  = 3'd1,
    REG_ONE_HIGH   = 3'd2,
    REG_ZERO_HIGH  = 3'd3,
    REG_BIT_PERIOD = 3'd4,
    REG_GAP_TIME   = 3'd5,
    REG_INVERT     = 3'd6
  } reg_idx_e;

  // line phases, one-hot
  typedef enum logic [4:0] {
    PH_IDLE       = 5'b00001,
    PH_START_HIGH = 5'b00010,
    PH_START_LOW  = 5'b00100,
    PH_DATA_HIGH  = 5'b01000,
    PH_DATA_LOW   = 5'b10000
  } phase_e;

endpackage

`default_nettype wire

// ----- hdl/pulse_width_code_transmitter_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_width_code_transmitter_top
// Sends a remote-switch code as on-off pulse-width keying. Each tick beat
// counts down the current line interval; a start beat loads a code word and
// a packet count when the transmitter is idle.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o | kind_i, code_word_i, repeat_count_i
//  out     | output    | out_valid_o/out_ready_i | line_level_o, line_driven_o,
//          |           |                         | busy_res_o, done_res_o
//  cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
//  one beat in, one beat out; the result is registered and shows in the cycle
//  after the input beat is taken; a new beat is taken every cycle unless a result waits
//  the interval counter, phase and bit counter update in a single pass
//  between the state registers and the result register
//  in_ready_o is high while the result register is empty or being emptied
//  reset returns to idle with the line released and the counters and config at zero
// ----------------------------------------------------------------------------
module pulse_width_code_transmitter_top #(
  parameter int unsigned CODE_BITS       = pwct_pkg::DefCodeBits,
  parameter int unsigned PULSE_EXTENSION = pwct_pkg::DefPulseExt,
  parameter int unsigned LATENCY_TICKS   = pwct_pkg::DefLatencyTicks
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration write port
  input  wire logic                             cfg_we_i,
  input  wire logic [pwct_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [pwct_pkg::CfgDataW-1:0]    cfg_wdata_i,
  // input beats
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             kind_i,
  input  wire logic [pwct_pkg::CodeWordW-1:0]   code_word_i,
  input  wire logic [pwct_pkg::RepeatW-1:0]     repeat_count_i,
  // result beats
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  line_level_o,
  output logic                                  line_driven_o,
  output logic                                  busy_res_o,
  output logic                                  done_res_o
);

  localparam int unsigned BitsW  = $clog2(CODE_BITS + 1);
  localparam int unsigned CalcW  = pwct_pkg::CalcW;
  localparam int unsigned CountW = pwct_pkg::CountW;
  localparam int unsigned TimeW  = pwct_pkg::TimeW;
  localparam logic signed [CalcW-1:0] HighAdj =
    CalcW'(PULSE_EXTENSION) - CalcW'(LATENCY_TICKS);
  localparam logic signed [CalcW-1:0] LowAdj =
    CalcW'(PULSE_EXTENSION) + CalcW'(LATENCY_TICKS);
  localparam logic [BitsW-1:0] CodeBitsV = BitsW'(CODE_BITS);

  // configuration registers
  logic [TimeW-1:0] start_high_q, start_low_q, one_high_q, zero_high_q;
  logic [TimeW-1:0] bit_period_q, gap_time_q;
  logic             invert_q;

  // transmitter state
  pwct_pkg::phase_e                 phase_q, phase_d;
  logic [pwct_pkg::CodeWordW-1:0]   shift_q, shift_d;
  logic [BitsW-1:0]                 bits_q, bits_d;
  logic [pwct_pkg::RepeatW-1:0]     packets_q, packets_d;
  logic [CountW-1:0]                cnt_q, cnt_d;
  logic signed [CountW-1:0]         pend_q, pend_d;
  logic                             drive_q, drive_d;

  // result register
  logic out_valid_q;
  logic level_q, driven_q, busy_q, done_q;
  logic done_d;

  // helper signals
  logic                      accept;
  logic                      is_idle;
  logic [CountW-1:0]         cnt_dec;
  logic [BitsW-1:0]          bits_eff;
  logic [5:0]                bit_idx;
  logic                      code_bit;
  logic                      data_go;
  logic [TimeW-1:0]          hi_time;
  logic signed [CalcW-1:0]   hi_n;
  logic [CountW-1:0]         hi_cnt;
  logic signed [CalcW-1:0]   hi_pend;
  logic signed [CalcW-1:0]   lo_time;
  logic signed [CalcW-1:0]   lo_n;
  logic [CountW-1:0]         lo_cnt;
  logic [pwct_pkg::RepeatW-1:0] packets_dec;
  logic                      level_d;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign is_idle    = (phase_q == pwct_pkg::PH_IDLE);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_high_q <= '0;
      start_low_q  <= '0;
      one_high_q   <= '0;
      zero_high_q  <= '0;
      bit_period_q <= '0;
      gap_time_q   <= '0;
      invert_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pwct_pkg::REG_START_HIGH: start_high_q <= cfg_wdata_i;
        pwct_pkg::REG_START_LOW:  start_low_q  <= cfg_wdata_i;
        pwct_pkg::REG_ONE_HIGH:   one_high_q   <= cfg_wdata_i;
        pwct_pkg::REG_ZERO_HIGH:  zero_high_q  <= cfg_wdata_i;
        pwct_pkg::REG_BIT_PERIOD: bit_period_q <= cfg_wdata_i;
        pwct_pkg::REG_GAP_TIME:   gap_time_q   <= cfg_wdata_i;
        pwct_pkg::REG_INVERT:     invert_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // counter step and current code bit
  assign cnt_dec  = (cnt_q == '0) ? '0 : cnt_q - CountW'(1);
  assign bits_eff = (phase_q == pwct_pkg::PH_START_LOW) ? CodeBitsV : bits_q;
  assign bit_idx  = 6'(bits_eff) - 6'd1;
  assign code_bit = (bit_idx < 6'(pwct_pkg::CodeWordW)) ? shift_q[bit_idx[4:0]] : 1'b0;
  // a data bit follows a start low or a data low while bits remain
  assign data_go  = !is_idle && (bits_eff != '0);

  // high interval: data bit time or start high time
  assign hi_time = (kind_i == pwct_pkg::KIND_TICK && data_go)
                 ? (code_bit ? one_high_q : zero_high_q) : start_high_q;
  assign hi_n    = $signed(CalcW'(hi_time)) + HighAdj;
  assign hi_cnt  = (hi_n < CalcW'(1)) ? CountW'(1) : hi_n[CountW-1:0];
  assign hi_pend = $signed(CalcW'(bit_period_q)) - $signed(CalcW'(hi_time))
                 + ((kind_i == pwct_pkg::KIND_TICK && bits_eff == BitsW'(1))
                    ? $signed(CalcW'(gap_time_q)) : CalcW'(0));

  // low interval: start low time or pending data low time
  assign lo_time = (phase_q == pwct_pkg::PH_START_HIGH)
                 ? $signed(CalcW'(start_low_q)) : CalcW'(pend_q);
  assign lo_n    = lo_time - LowAdj;
  assign lo_cnt  = (lo_n < CalcW'(1)) ? CountW'(1) : lo_n[CountW-1:0];

  assign packets_dec = packets_q - pwct_pkg::RepeatW'(1);

  // next state for one beat
  always_comb begin
    phase_d   = phase_q;
    shift_d   = shift_q;
    bits_d    = bits_q;
    packets_d = packets_q;
    cnt_d     = cnt_q;
    pend_d    = pend_q;
    drive_d   = drive_q;
    done_d    = 1'b0;
    if (accept) begin
      if (kind_i == pwct_pkg::KIND_START) begin
        if (is_idle) begin
          shift_d   = code_word_i;
          packets_d = repeat_count_i;
          bits_d    = '0;
          drive_d   = 1'b1;
          phase_d   = pwct_pkg::PH_START_HIGH;
          cnt_d     = hi_cnt;
          pend_d    = hi_pend[CountW-1:0];
        end
      end else if (!is_idle) begin
        cnt_d = cnt_dec;
        if (cnt_dec == '0) begin
          case (phase_q)
            pwct_pkg::PH_START_HIGH: begin
              phase_d = pwct_pkg::PH_START_LOW;
              cnt_d   = lo_cnt;
            end
            pwct_pkg::PH_DATA_HIGH: begin
              phase_d = pwct_pkg::PH_DATA_LOW;
              cnt_d   = lo_cnt;
            end
            default: begin
              if (data_go) begin
                phase_d = pwct_pkg::PH_DATA_HIGH;
                cnt_d   = hi_cnt;
                pend_d  = hi_pend[CountW-1:0];
                bits_d  = bits_eff - BitsW'(1);
              end else begin
                packets_d = packets_dec;
                if (packets_dec != '0) begin
                  phase_d = pwct_pkg::PH_START_HIGH;
                  cnt_d   = hi_cnt;
                  pend_d  = hi_pend[CountW-1:0];
                end else begin
                  phase_d = pwct_pkg::PH_IDLE;
                  drive_d = 1'b0;
                  cnt_d   = '0;
                  done_d  = 1'b1;
                end
              end
            end
          endcase
        end
      end
    end
  end

  assign level_d = (phase_d == pwct_pkg::PH_START_HIGH)
                || (phase_d == pwct_pkg::PH_DATA_HIGH);

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= pwct_pkg::PH_IDLE;
      shift_q   <= '0;
      bits_q    <= '0;
      packets_q <= '0;
      cnt_q     <= '0;
      pend_q    <= '0;
      drive_q   <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      shift_q   <= shift_d;
      bits_q    <= bits_d;
      packets_q <= packets_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
      drive_q   <= drive_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      level_q  <= level_d ^ invert_q;
      driven_q <= drive_d;
      busy_q   <= (phase_d != pwct_pkg::PH_IDLE);
      done_q   <= done_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign line_level_o  = level_q;
  assign line_driven_o = driven_q;
  assign busy_res_o    = busy_q;
  assign done_res_o    = done_q;

  // idle means released line and a cleared counter
  a_idle_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == pwct_pkg::PH_IDLE) |-> (!drive_q && cnt_q == '0))
    else $error("idle with driver enabled or counter running");

  // an active interval always has ticks left
  a_active_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != pwct_pkg::PH_IDLE) |-> (cnt_q != '0 && drive_q))
    else $error("active phase with empty interval counter");

  // a done beat reports the finished, released line
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_q) |-> (!busy_q && !driven_q))
    else $error("done reported while still busy");

  // bit counter never exceeds the code length
  a_bits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q <= CodeBitsV)
    else $error("bit counter out of range");

  // a start taken while idle opens a start pulse
  a_start_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i == pwct_pkg::KIND_START && phase_q == pwct_pkg::PH_IDLE)
    |=> (phase_q == pwct_pkg::PH_START_HIGH))
    else $error("start beat did not open a start pulse");

endmodule

`default_nettype wire
